### design/utf8tc_pkg.sv
`default_nettype none

package utf8tc_pkg;

	// Longest buffer that is judged; later bytes only count for the end marker.
	localparam int MAX_LEN = 512;
	localparam int POS_W   = $clog2(MAX_LEN + 1);

	// Widths of the transaction fields.
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 10;
	localparam int REASON_W = 3;
	localparam int PEND_W   = 3;

	typedef enum logic [REASON_W-1:0] {
		REASON_CLEAN      = 3'd0,
		REASON_ASCII_IN   = 3'd1,
		REASON_STRAY_CONT = 3'd2,
		REASON_LEAD_IN    = 3'd3,
		REASON_TRUNCATED  = 3'd4
	} reason_t;

	// Decoded view of one byte.
	typedef struct packed {
		logic              is_ascii;
		logic              is_cont;
		logic              is_lead;
		logic [PEND_W-1:0] cont_count;
	} byte_class_t;

	// One finished verdict on a buffer.
	typedef struct packed {
		logic [LEN_W-1:0] usable_length;
		reason_t          cut_reason;
	} verdict_t;

endpackage

`default_nettype wire

### design/utf8tc_if.sv
`default_nettype none

interface utf8tc_in_if import utf8tc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8tc_out_if import utf8tc_pkg::*;;
	logic                valid;
	logic                ready;
	logic [LEN_W-1:0]    usable_length;
	logic [REASON_W-1:0] cut_reason;

	modport source (output valid, output usable_length, output cut_reason, input ready);
	modport sink (input valid, input usable_length, input cut_reason, output ready);
endinterface

`default_nettype wire

### design/utf8tc_classify.sv
`default_nettype none

module utf8tc_classify import utf8tc_pkg::*; (
	input  wire logic [BYTE_W-1:0] data_byte,
	output byte_class_t            cls
);

	// A lead byte expects one continuation fewer than its leading ones.
	// Eight leading ones give seven, which still fits the three-bit count.
	// The count only matters for lead bytes, whose top two bits are ones.
	always_comb begin
		cls.is_ascii = ~data_byte[7];
		cls.is_cont  = (data_byte[7:6] == 2'b10);
		cls.is_lead  = (data_byte[7:6] == 2'b11);
		if (!data_byte[5]) begin
			cls.cont_count = 3'd1;
		end else if (!data_byte[4]) begin
			cls.cont_count = 3'd2;
		end else if (!data_byte[3]) begin
			cls.cont_count = 3'd3;
		end else if (!data_byte[2]) begin
			cls.cont_count = 3'd4;
		end else if (!data_byte[1]) begin
			cls.cont_count = 3'd5;
		end else if (!data_byte[0]) begin
			cls.cont_count = 3'd6;
		end else begin
			cls.cont_count = 3'd7;
		end
	end

endmodule

`default_nettype wire

### design/utf8tc_track.sv
`default_nettype none

module utf8tc_track import utf8tc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        last_byte,
	input  wire byte_class_t cls,
	output verdict_t         verdict
);

	logic [PEND_W-1:0] pend_q, pend_n;
	logic [POS_W-1:0]  start_q, start_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic              err_q, err_n;
	logic [POS_W-1:0]  cut_len_q, cut_len_n;
	reason_t           cut_code_q, cut_code_n;
	logic              take;

	// Bytes after the first error or past the length limit leave the state alone.
	assign take = ~err_q & (pos_q < POS_W'(MAX_LEN));

	always_comb begin
		pend_n     = pend_q;
		start_n    = start_q;
		pos_n      = pos_q;
		err_n      = err_q;
		cut_len_n  = cut_len_q;
		cut_code_n = cut_code_q;
		if (take) begin
			pos_n = pos_q + POS_W'(1);
			if (cls.is_ascii) begin
				if (pend_q != '0) begin
					err_n      = 1'b1;
					cut_len_n  = start_q;
					cut_code_n = REASON_ASCII_IN;
				end
			end else if (cls.is_cont) begin
				if (pend_q != '0) begin
					pend_n = pend_q - PEND_W'(1);
				end else begin
					err_n      = 1'b1;
					cut_len_n  = pos_q;
					cut_code_n = REASON_STRAY_CONT;
				end
			end else if (cls.is_lead) begin
				if (pend_q == '0) begin
					start_n = pos_q;
					pend_n  = cls.cont_count;
				end else begin
					err_n      = 1'b1;
					cut_len_n  = start_q;
					cut_code_n = REASON_LEAD_IN;
				end
			end
		end
	end

	always_comb begin
		if (err_n) begin
			verdict.usable_length = LEN_W'(cut_len_n);
			verdict.cut_reason    = cut_code_n;
		end else if (pend_n != '0) begin
			verdict.usable_length = LEN_W'(start_n);
			verdict.cut_reason    = REASON_TRUNCATED;
		end else begin
			verdict.usable_length = LEN_W'(pos_n);
			verdict.cut_reason    = REASON_CLEAN;
		end
	end

	// The final byte of a buffer returns everything to the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			start_q    <= '0;
			pos_q      <= '0;
			err_q      <= 1'b0;
			cut_len_q  <= '0;
			cut_code_q <= REASON_CLEAN;
		end else if (step) begin
			if (last_byte) begin
				pend_q     <= '0;
				start_q    <= '0;
				pos_q      <= '0;
				err_q      <= 1'b0;
				cut_len_q  <= '0;
				cut_code_q <= REASON_CLEAN;
			end else begin
				pend_q     <= pend_n;
				start_q    <= start_n;
				pos_q      <= pos_n;
				err_q      <= err_n;
				cut_len_q  <= cut_len_n;
				cut_code_q <= cut_code_n;
			end
		end
	end

endmodule

`default_nettype wire

### design/utf8_truncation_checker_unit.sv
// UTF-8 truncation checker.
// The data channel carries one byte of a buffer per transaction, with
// last_byte marking the final byte. For each buffer the verdict channel
// carries exactly one transaction: usable_length, the length of the longest
// prefix made only of complete UTF-8 sequences, and cut_reason, which names
// the first error (clean, ASCII inside a sequence, stray continuation, lead
// byte inside a sequence, or a sequence left unfinished at the end).
// Bytes after the first error, and bytes past MAX_LEN, do not move the cut.
// Throughput is one byte per cycle while no last byte waits: a byte is
// registered in an input stage, and as it leaves that stage a short decode
// and update of the tracking state runs, with the verdict captured in an
// output register that drives the verdict channel. When the verdict
// receiver stalls, bytes that are not the last of a buffer keep flowing;
// only a last byte waits in the input stage until the output register is
// free, and the data channel then holds ready low.
// An asynchronous reset (arst_n low) empties both stages and clears the
// tracking state, so the next byte taken starts a new buffer. There is no
// clearing pass after reset.
`default_nettype none

module utf8_truncation_checker_unit import utf8tc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	utf8tc_in_if.sink   data,
	utf8tc_out_if.source verdict
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              valid_s2;
	verdict_t          verdict_s2;
	logic              advance;
	byte_class_t       cls;
	verdict_t          verdict_next;

	// The input stage moves on when its byte produces no verdict, or when the
	// output register is empty or being emptied in this cycle.
	assign advance    = valid_s1 & (~last_s1 | ~valid_s2 | verdict.ready);
	assign data.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.ready) begin
			valid_s1 <= data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data.ready && data.valid) begin
			byte_s1 <= data.data_byte;
			last_s1 <= data.last_byte;
		end
	end

	utf8tc_classify u_classify (
		.data_byte (byte_s1),
		.cls       (cls)
	);

	utf8tc_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.last_byte (last_s1),
		.cls       (cls),
		.verdict   (verdict_next)
	);

	// The output register holds a verdict until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (verdict.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			verdict_s2 <= verdict_next;
		end
	end

	assign verdict.valid         = valid_s2;
	assign verdict.usable_length = verdict_s2.usable_length;
	assign verdict.cut_reason    = verdict_s2.cut_reason;

endmodule

`default_nettype wire
